// File: rtl/core/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg
// shared constants, status codes and request/response types for the
// binary min-heap priority queue
// ---------------------------------------------------------------------------
package bmhq_pkg;

	localparam int CAPACITY  = 1024;
	localparam int KEY_WIDTH = 32;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CHILD_W   = CNT_W + 1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// request actions
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [KEY_WIDTH-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] removed_key;
		logic [KEY_WIDTH-1:0] min_key;
		logic [CNT_W-1:0]     count;
		logic [1:0]           status;
	} rsp_t;

endpackage

// File: rtl/core/binary_min_heap_queue.sv
// ---------------------------------------------------------------------------
// binary_min_heap_queue
// min-heap priority queue of unsigned keys kept in one synchronous ram;
// insert sifts up, remove returns the root and sifts the last key down
// ---------------------------------------------------------------------------
//
//  channel    signals            direction  notes
//  request    start, busy, req   in         accepted when start && !busy
//  response   done, rsp          out        done high one cycle, no stall
//
// steps per request, from the accept to the done strobe:
//   insert       a parent read per level climbed (empty heap: root write)
//   remove       last key fetched, then child reads per level descended
//                (no sift when the last key is taken)
//   full/empty   flagged, heap unchanged
// the single read port of the key ram sets this: one key read per cycle and
// registered read data, two child reads and a decision per level down
// reset clears the count and the controller only; ram contents need no clear
// since only slots below the count are ever read. the receiver cannot stall:
// a new request may be accepted in the same cycle as the done strobe
//
module binary_min_heap_queue
	import bmhq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// controller states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_UP      = 3'd1;
	localparam logic [2:0] S_PUT     = 3'd2;
	localparam logic [2:0] S_DN_LAST = 3'd3;
	localparam logic [2:0] S_DN_L    = 3'd4;
	localparam logic [2:0] S_DN_R    = 3'd5;
	localparam logic [2:0] S_DN_C    = 3'd6;
	localparam logic [2:0] S_DONE    = 3'd7;

	// key ram
	logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
	logic [KEY_WIDTH-1:0] mem_rdata_q;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [KEY_WIDTH-1:0] mem_wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_raddr;

	// control and datapath registers
	logic [2:0]           state_q, state_n;
	logic [CNT_W-1:0]     count_q, count_n;
	logic [CNT_W-1:0]     pos_q, pos_n;       // 1-based heap position of the hole
	logic [KEY_WIDTH-1:0] key_q, key_n;       // key being sifted
	logic [KEY_WIDTH-1:0] best_q, best_n;     // smaller of key and left child
	logic                 left_q, left_n;     // left child beat the key
	logic [KEY_WIDTH-1:0] removed_q, removed_n;
	logic [1:0]           status_q, status_n;
	logic [KEY_WIDTH-1:0] root_q;             // copy of slot 0
	rsp_t                 rsp_q, rsp_n;
	logic                 done_q, done_n;

	// heap arithmetic
	logic [CNT_W-1:0]   par;
	logic [CNT_W-1:0]   gpar;
	logic [CHILD_W-1:0] lft;
	logic [CHILD_W-1:0] rgt;
	logic [CHILD_W-1:0] cnt_ext;
	logic [CNT_W-1:0]   ins_pos;
	logic [CNT_W-1:0]   last_idx;
	logic [CHILD_W-1:0] lft_m1;
	logic [CHILD_W-1:0] rgt_m1;
	logic [CNT_W-1:0]   pos_m1;
	logic [CNT_W-1:0]   par_m1;
	logic [CNT_W-1:0]   gpar_m1;
	logic [CNT_W-1:0]   ins_par_m1;

	assign par        = pos_q >> 1;
	assign gpar       = par >> 1;
	assign lft        = {pos_q, 1'b0};
	assign rgt        = {pos_q, 1'b1};
	assign cnt_ext    = {1'b0, count_q};
	assign ins_pos    = count_q + CNT_W'(1);
	assign last_idx   = count_q - CNT_W'(1);
	assign lft_m1     = lft - CHILD_W'(1);
	assign rgt_m1     = rgt - CHILD_W'(1);
	assign pos_m1     = pos_q - CNT_W'(1);
	assign par_m1     = par - CNT_W'(1);
	assign gpar_m1    = gpar - CNT_W'(1);
	assign ins_par_m1 = (ins_pos >> 1) - CNT_W'(1);

	always_comb begin
		state_n   = state_q;
		count_n   = count_q;
		pos_n     = pos_q;
		key_n     = key_q;
		best_n    = best_q;
		left_n    = left_q;
		removed_n = removed_q;
		status_n  = status_q;
		rsp_n     = rsp_q;
		done_n    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_m1[ADDR_W-1:0];
		mem_wdata = key_q;
		mem_re    = 1'b0;
		mem_raddr = par_m1[ADDR_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					status_n  = ST_OK;
					removed_n = '0;
					key_n     = req.key;
					state_n   = S_DONE;
					if (req.action == ACT_INSERT) begin
						if (count_q >= CNT_W'(CAPACITY)) begin
							status_n = ST_FULL;
						end else if (count_q == '0) begin
							// first key goes straight to the root
							count_n   = ins_pos;
							mem_we    = 1'b1;
							mem_waddr = '0;
							mem_wdata = req.key;
						end else begin
							count_n   = ins_pos;
							pos_n     = ins_pos;
							mem_re    = 1'b1;
							mem_raddr = ins_par_m1[ADDR_W-1:0];
							state_n   = S_UP;
						end
					end else begin
						if (count_q == '0) begin
							status_n = ST_EMPTY;
						end else begin
							removed_n = root_q;
							count_n   = last_idx;
							pos_n     = CNT_W'(1);
							if (count_q != CNT_W'(1)) begin
								// fetch the last key, it becomes the new root
								mem_re    = 1'b1;
								mem_raddr = last_idx[ADDR_W-1:0];
								state_n   = S_DN_LAST;
							end
						end
					end
				end
			end

			S_UP: begin
				// read data holds the parent of the hole
				mem_we = 1'b1;
				if (key_q < mem_rdata_q) begin
					// parent moves down into the hole
					mem_wdata = mem_rdata_q;
					pos_n     = par;
					if (par == CNT_W'(1)) begin
						state_n = S_PUT;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = gpar_m1[ADDR_W-1:0];
					end
				end else begin
					state_n = S_DONE;
				end
			end

			S_PUT: begin
				// key settles at the root
				mem_we  = 1'b1;
				state_n = S_DONE;
			end

			S_DN_LAST: begin
				key_n   = mem_rdata_q;
				state_n = S_DN_L;
			end

			S_DN_L: begin
				if (lft <= cnt_ext) begin
					mem_re    = 1'b1;
					mem_raddr = lft_m1[ADDR_W-1:0];
					state_n   = S_DN_R;
				end else begin
					// leaf reached
					mem_we  = 1'b1;
					state_n = S_DONE;
				end
			end

			S_DN_R: begin
				// read data holds the left child
				left_n = mem_rdata_q < key_q;
				best_n = left_n ? mem_rdata_q : key_q;
				if (rgt <= cnt_ext) begin
					mem_re    = 1'b1;
					mem_raddr = rgt_m1[ADDR_W-1:0];
					state_n   = S_DN_C;
				end else if (left_n) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata_q;
					pos_n     = lft[CNT_W-1:0];
					state_n   = S_DN_L;
				end else begin
					mem_we  = 1'b1;
					state_n = S_DONE;
				end
			end

			S_DN_C: begin
				// read data holds the right child
				mem_we = 1'b1;
				if (mem_rdata_q < best_q) begin
					mem_wdata = mem_rdata_q;
					pos_n     = rgt[CNT_W-1:0];
					state_n   = S_DN_L;
				end else if (left_q) begin
					mem_wdata = best_q;
					pos_n     = lft[CNT_W-1:0];
					state_n   = S_DN_L;
				end else begin
					state_n = S_DONE;
				end
			end

			S_DONE: begin
				// root copy is up to date here
				rsp_n.removed_key = removed_q;
				rsp_n.min_key     = (count_q != '0) ? root_q : '0;
				rsp_n.count       = count_q;
				rsp_n.status      = status_q;
				done_n            = 1'b1;
				state_n           = S_IDLE;
			end

			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// key ram, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= key_mem[mem_raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			done_q  <= done_n;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q     <= pos_n;
		key_q     <= key_n;
		best_q    <= best_n;
		left_q    <= left_n;
		removed_q <= removed_n;
		status_q  <= status_n;
		rsp_q     <= rsp_n;
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: rtl/core/bmhq_checker.sv
// ---------------------------------------------------------------------------
// bmhq_checker
// port-level checks on the heap queue's request and response behavior
// ---------------------------------------------------------------------------
module bmhq_checker
	import bmhq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// an accepted request keeps the block busy the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// the strobe only appears once the work is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response strobed while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.count <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.count == '0 |-> rsp.min_key == '0)
		else $error("empty heap reports a nonzero minimum");

	a_empty_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.removed_key == '0)
		else $error("remove on empty with keys held or key returned");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
